FILE: hw/rtl/aarm_pkg.sv
// -----------------------------------------------------------------------------
// Axis-angle rotation matrix package
// Shared widths, angle constants, the arctangent table and the word type that
// runs along the CORDIC chain.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aarm_pkg;

  // Widths of the datapath.
  localparam int AngleW   = 16;
  localparam int CordW    = 28;   // x, y, z of the CORDIC chain, Q.24
  localparam int AxisW    = 16;
  localparam int CenterW  = 32;
  localparam int RotW     = 16;
  localparam int TransW   = 35;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // CORDIC step count.
  localparam int CordicStepsDef = 16;
  localparam int AtanEntries    = 24;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_AXIS_X   = 3'd3,
    REG_AXIS_Y   = 3'd4,
    REG_AXIS_Z   = 3'd5
  } cfg_reg_e;

  // Angles in units of 2^-24 rad.
  localparam logic signed [CordW:0] AngPi     = 29'sd52707179;
  localparam logic signed [CordW:0] AngTwoPi  = 29'sd105414357;
  localparam logic signed [CordW:0] AngHalfPi = 29'sd26353589;
  localparam logic signed [CordW-1:0] GainInv = 28'sd10188014;

  // atan(2^-i) in 2^-24 rad, rounded to nearest.
  localparam logic signed [CordW-1:0] AtanTab [AtanEntries] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
    28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
    28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
    28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
    28'sd256,      28'sd128,     28'sd64,      28'sd32,
    28'sd16,       28'sd8,       28'sd4,       28'sd2
  };

  // One word moving along the CORDIC chain.
  typedef struct packed {
    logic                    vld;
    logic                    flip;
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [CordW-1:0] z;
  } cordic_t;

endpackage

`default_nettype wire

FILE: hw/rtl/axis_angle_rotation_matrix_unit.sv
// -----------------------------------------------------------------------------
// Axis-angle rotation matrix unit
// Builds the rotation entries and translation row for a rotation about a
// configured axis through a configured center point.
// -----------------------------------------------------------------------------
// The unit takes one angle word per clock while it is not stalled and returns
// one matrix word per angle, in order. The pipeline has one register of angle
// folding, one CORDIC cell per step, then six registered stages for sine and
// cosine rounding, the two products of the Rodrigues terms, entry rounding,
// the center products and the translation sum. The whole pipeline advances
// whenever the output register is empty or being taken, so the sustained rate
// is one word per cycle. Write the center and axis registers only while no
// word is in flight.
`timescale 1ns / 1ps
`default_nettype none

module axis_angle_rotation_matrix_unit import aarm_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic signed [AngleW-1:0]    angle_i,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic        [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic        [CfgDataW-1:0]  cfg_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [RotW-1:0]           rot_00_o,
  output logic signed [RotW-1:0]           rot_01_o,
  output logic signed [RotW-1:0]           rot_02_o,
  output logic signed [RotW-1:0]           rot_10_o,
  output logic signed [RotW-1:0]           rot_11_o,
  output logic signed [RotW-1:0]           rot_12_o,
  output logic signed [RotW-1:0]           rot_20_o,
  output logic signed [RotW-1:0]           rot_21_o,
  output logic signed [RotW-1:0]           rot_22_o,
  output logic signed [TransW-1:0]         trans_x_o,
  output logic signed [TransW-1:0]         trans_y_o,
  output logic signed [TransW-1:0]         trans_z_o
);

  localparam int CsW  = 19;
  localparam int TW   = CsW + 1;
  localparam int TaW  = TW + AxisW;
  localparam int SaW  = CsW + AxisW;
  localparam int PW   = TaW + AxisW;
  localparam int AccW = PW + 2;
  localparam int CpW  = CenterW + RotW;
  localparam int SumW = CpW + 3;

  logic en;

  // Configuration registers.
  logic signed [CenterW-1:0] cen_q  [3];
  logic signed [AxisW-1:0]   axis_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        cen_q[k]  <= '0;
        axis_q[k] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CENTER_X: cen_q[0]  <= cfg_data_i;
        REG_CENTER_Y: cen_q[1]  <= cfg_data_i;
        REG_CENTER_Z: cen_q[2]  <= cfg_data_i;
        REG_AXIS_X:   axis_q[0] <= cfg_data_i[AxisW-1:0];
        REG_AXIS_Y:   axis_q[1] <= cfg_data_i[AxisW-1:0];
        REG_AXIS_Z:   axis_q[2] <= cfg_data_i[AxisW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Pipeline advances when the output register is free or being read.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Sine and cosine from the CORDIC chain.
  cordic_t cord;

  aarm_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .angle_i(angle_i),
    .out_o  (cord)
  );

  logic signed [CordW-1:0] cx, cy;
  logic signed [CordW:0]   cxr, cyr;
  logic signed [CsW-1:0]   c_q, s_q;
  logic                    vcs_q;

  // Undo the half-turn fold and round to Q.14.
  always_comb begin
    cx  = cord.flip ? -cord.x : cord.x;
    cy  = cord.flip ? -cord.y : cord.y;
    cxr = ((CordW+1)'(cx) + (CordW+1)'(512)) >>> 10;
    cyr = ((CordW+1)'(cy) + (CordW+1)'(512)) >>> 10;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q <= cxr[CsW-1:0];
      s_q <= cyr[CsW-1:0];
    end
  end

  // First products: t times axis and s times axis.
  logic signed [TW-1:0]  t;
  logic signed [TaW-1:0] ta_q [3];
  logic signed [SaW-1:0] sa_q [3];
  logic signed [SaW-1:0] sab_q [3];
  logic signed [CsW-1:0] ca_q, cb_q;
  logic                  va_q, vb_q, vc_q, vd_q;

  assign t = TW'(16384) - TW'(c_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ta_q[k] <= TaW'(t) * TaW'(axis_q[k]);
        sa_q[k] <= SaW'(s_q) * SaW'(axis_q[k]);
      end
      ca_q <= c_q;
    end
  end

  // Second products: t * a_r * a_c.
  logic signed [PW-1:0] p_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p_q[r][c] <= PW'(ta_q[r]) * PW'(axis_q[c]);
        end
        sab_q[r] <= sa_q[r];
      end
      cb_q <= ca_q;
    end
  end

  // Sum the Rodrigues terms, round once and saturate each entry.
  logic signed [RotW-1:0] rot_d [3][3];
  logic signed [RotW-1:0] rot_q [3][3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      logic signed [AccW-1:0] acc, rnd;
      always_comb begin
        acc = AccW'(p_q[r][c]) + (AccW'(1) <<< 27);
        if (r == c) begin
          acc = acc + (AccW'(cb_q) <<< 28);
        end else if (((c - r + 3) % 3) == 2) begin
          acc = acc + (AccW'(sab_q[3-r-c]) <<< 14);
        end else begin
          acc = acc - (AccW'(sab_q[3-r-c]) <<< 14);
        end
        rnd = acc >>> 28;
        if (rnd > AccW'(32767)) begin
          rot_d[r][c] = RotW'(32767);
        end else if (rnd < -AccW'(32768)) begin
          rot_d[r][c] = -RotW'(32768);
        end else begin
          rot_d[r][c] = rnd[RotW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rot_q <= rot_d;
    end
  end

  // Center products for the translation row.
  logic signed [CpW-1:0]  cp_q  [3][3];
  logic signed [RotW-1:0] rotd_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        for (int r = 0; r < 3; r++) begin
          cp_q[j][r] <= CpW'(cen_q[r]) * CpW'(rot_q[r][j]);
        end
      end
      rotd_q <= rot_q;
    end
  end

  // Translation: center minus the rotated center, rounded and saturated.
  logic signed [TransW-1:0] trans_d [3];
  logic signed [TransW-1:0] trans_q [3];
  logic signed [RotW-1:0]   rote_q  [3][3];

  for (genvar j = 0; j < 3; j++) begin : g_trans
    logic signed [SumW-1:0] sum, rnd;
    always_comb begin
      sum = (SumW'(cen_q[j]) <<< 14) - SumW'(cp_q[j][0]) - SumW'(cp_q[j][1])
          - SumW'(cp_q[j][2]) + SumW'(8192);
      rnd = sum >>> 14;
      if (rnd > ((SumW'(1) <<< (TransW-1)) - SumW'(1))) begin
        trans_d[j] = {1'b0, {(TransW-1){1'b1}}};
      end else if (rnd < -(SumW'(1) <<< (TransW-1))) begin
        trans_d[j] = {1'b1, {(TransW-1){1'b0}}};
      end else begin
        trans_d[j] = rnd[TransW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      trans_q <= trans_d;
      rote_q  <= rotd_q;
    end
  end

  // Valid bits along the back end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcs_q       <= 1'b0;
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      vd_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      vcs_q       <= cord.vld;
      va_q        <= vcs_q;
      vb_q        <= va_q;
      vc_q        <= vb_q;
      vd_q        <= vc_q;
      out_valid_o <= vd_q;
    end
  end

  assign rot_00_o  = rote_q[0][0];
  assign rot_01_o  = rote_q[0][1];
  assign rot_02_o  = rote_q[0][2];
  assign rot_10_o  = rote_q[1][0];
  assign rot_11_o  = rote_q[1][1];
  assign rot_12_o  = rote_q[1][2];
  assign rot_20_o  = rote_q[2][0];
  assign rot_21_o  = rote_q[2][1];
  assign rot_22_o  = rote_q[2][2];
  assign trans_x_o = trans_q[0];
  assign trans_y_o = trans_q[1];
  assign trans_z_o = trans_q[2];

endmodule

`default_nettype wire

FILE: hw/rtl/aarm_cordic_cell.sv
// -----------------------------------------------------------------------------
// CORDIC cell
// One rotation-mode micro-rotation with its own fixed shift and arctangent,
// registered toward the next cell of the chain.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aarm_cordic_cell import aarm_pkg::*; #(
  parameter int Idx = 0
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    en_i,
  input  wire cordic_t in_i,
  output cordic_t      out_o
);

  cordic_t                 cell_d, cell_q;
  logic signed [CordW-1:0] x_in, y_in, z_in, dx, dy;

  // Rotate toward zero residual angle; shifts are arithmetic.
  always_comb begin
    x_in = in_i.x;
    y_in = in_i.y;
    z_in = in_i.z;
    dx = y_in >>> Idx;
    dy = x_in >>> Idx;
    cell_d = in_i;
    if (!z_in[CordW-1]) begin
      cell_d.x = x_in - dx;
      cell_d.y = y_in + dy;
      cell_d.z = z_in - AtanTab[Idx];
    end else begin
      cell_d.x = x_in + dx;
      cell_d.y = y_in - dy;
      cell_d.z = z_in + AtanTab[Idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign out_o = cell_q;

endmodule

`default_nettype wire

FILE: hw/rtl/aarm_cordic.sv
// -----------------------------------------------------------------------------
// CORDIC chain
// Folds the negated angle into minus half pi to half pi and runs it through a
// row of CORDIC cells, one micro-rotation per cell.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aarm_cordic import aarm_pkg::*; #(
  parameter int Steps = CordicStepsDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     vld_i,
  input  wire logic signed [AngleW-1:0] angle_i,
  output cordic_t                       out_o
);

  localparam int NumCells = (Steps > AtanEntries) ? AtanEntries : Steps;

  cordic_t               red_d, red_q;
  cordic_t               chain [NumCells+1];
  logic signed [CordW:0] z_neg, z_wrap, z_half;
  logic                  flip;

  // Negate, scale to 2^-24 rad and fold into the CORDIC range.
  always_comb begin
    z_neg = -((CordW+1)'(angle_i) <<< 12);
    z_wrap = z_neg;
    if (z_neg > AngPi) begin
      z_wrap = z_neg - AngTwoPi;
    end else if (z_neg < -AngPi) begin
      z_wrap = z_neg + AngTwoPi;
    end
    z_half = z_wrap;
    flip = 1'b0;
    if (z_wrap > AngHalfPi) begin
      z_half = z_wrap - AngPi;
      flip = 1'b1;
    end else if (z_wrap < -AngHalfPi) begin
      z_half = z_wrap + AngPi;
      flip = 1'b1;
    end
    red_d.vld  = vld_i;
    red_d.flip = flip;
    red_d.x    = GainInv;
    red_d.y    = '0;
    red_d.z    = z_half[CordW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q <= '0;
    end else if (en_i) begin
      red_q <= red_d;
    end
  end

  assign chain[0] = red_q;

  // The row of cells.
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    aarm_cordic_cell #(.Idx(i)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en_i),
      .in_i  (chain[i]),
      .out_o (chain[i+1])
    );
  end

  assign out_o = chain[NumCells];

endmodule

`default_nettype wire

FILE: hw/rtl/aarm_checker.sv
// -----------------------------------------------------------------------------
// Axis-angle rotation matrix checker
// Port-level assertions on the unit's handshakes, bound to the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aarm_checker import aarm_pkg::*; (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_ready_o,
  input wire logic                       cfg_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic signed [RotW-1:0]     rot_00_o,
  input wire logic signed [TransW-1:0]   trans_x_o
);

  // A stalled output word keeps its valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(rot_00_o) && $stable(trans_x_o))
    else $error("output word changed while stalled");

  // A full, stalled output stage holds off new input words.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while the pipeline is stalled");

  // An empty output stage always takes new words.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o && cfg_ready_o)
    else $error("unit not ready while output is empty");

endmodule

bind axis_angle_rotation_matrix_unit aarm_checker u_aarm_checker (.*);

`default_nettype wire
